@@ hdl/wra_pkg.sv @@
package wra_pkg;

	localparam int MAX_WINDOW = 131072;
	localparam int LEN_W = $clog2(MAX_WINDOW);
	localparam int LANES = 2;
	localparam int SAMPLE_W = 24;
	localparam int FRAC_W = 17;
	localparam int FRAC_SH = 16;
	localparam int UNITY = 65536;
	localparam int FADE_SH = 17;
	localparam int PROD_W = SAMPLE_W + FRAC_W + 1;
	localparam int ACC_W = PROD_W + 1;
	localparam int DIV_STEPS = FRAC_SH / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
	localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));
	localparam int WINDOW_LEN_RST = 24000;
	localparam int CROSSFADE_RST = 9830;
	localparam int MIX_RST = 65536;
	localparam int ACTIVE_LEN_RST = (WINDOW_LEN_RST < MAX_WINDOW) ? WINDOW_LEN_RST
		: MAX_WINDOW - 1;

	typedef enum logic [1:0] {
		REG_WINDOW_LEN,
		REG_CROSSFADE,
		REG_MIX
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FADE,
		ST_DIV,
		ST_WET,
		ST_MIX,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic mem_en;
		logic cap_half;
		logic [LEN_W-1:0] wr_slot;
		logic [LEN_W-1:0] rd_slot;
		logic dry_en;
		logic wet_en;
		logic mix_en;
		logic sum_en;
		logic played;
		logic [FRAC_W-1:0] env;
		logic [FRAC_W-1:0] mix;
		logic [FRAC_W-1:0] mix_inv;
	} lane_ctl_t;

	// divide by unity, rounding toward zero
	function automatic logic signed [ACC_W-FRAC_SH-1:0] div_unity(
		input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] b;
		b = x[ACC_W-1] ? x + ACC_W'(UNITY - 1) : x;
		return b[ACC_W-1:FRAC_SH];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(
		input logic signed [ACC_W-FRAC_SH-1:0] x);
		logic signed [SAMPLE_W-1:0] r;
		if (x > SAMPLE_MAX) begin
			r = SAMPLE_W'(SAMPLE_MAX);
		end else if (x < SAMPLE_MIN) begin
			r = SAMPLE_W'(SAMPLE_MIN);
		end else begin
			r = SAMPLE_W'(x);
		end
		return r;
	endfunction

endpackage

@@ hdl/windowed_reverse_audio_top.sv @@
// channel   direction  handshake            payload
// config    in/out     psel/penable/pready  paddr, pwdata, prdata
// input     in         in_valid/in_ready    left_in, right_in
// output    out        out_valid/out_ready  left_out, right_out
//
// one frame at a time: accept, fade, wet, mix, sum and output load come before the next ready;
// inside a fade a divide state is added, where the envelope divider yields two quotient bits a cycle
// the finished frame sits in the output register while the next frame is taken in
// out_ready low holds the result and stops the sequencer before the output load
// asynchronous reset clears position, ping-pong half and the first-window flag;
// sample memory holds garbage until written and is never cleared
module windowed_reverse_audio_top (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [wra_pkg::ADDR_W-1:0] paddr,
	input  logic [wra_pkg::DATA_W-1:0] pwdata,
	output logic [wra_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [wra_pkg::SAMPLE_W-1:0] left_in,
	input  logic signed [wra_pkg::SAMPLE_W-1:0] right_in,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [wra_pkg::SAMPLE_W-1:0] left_out,
	output logic signed [wra_pkg::SAMPLE_W-1:0] right_out
);
	import wra_pkg::*;

	lane_ctl_t lane_ctl;
	logic out_free, out_load;
	logic signed [SAMPLE_W-1:0] lane_dry [LANES];
	logic signed [SAMPLE_W-1:0] lane_res [LANES];

	assign pready = 1'b1;
	assign lane_dry[0] = left_in;
	assign lane_dry[1] = right_in;

	wra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.out_load (out_load),
		.lane_ctl (lane_ctl)
	);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		wra_lane u_lane (
			.clk    (clk),
			.ctl    (lane_ctl),
			.dry    (lane_dry[i]),
			.result (lane_res[i])
		);
	end

	wra_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.lane_res  (lane_res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.left_out  (left_out),
		.right_out (right_out),
		.free      (out_free)
	);

endmodule

@@ hdl/wra_ctrl.sv @@
module wra_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [wra_pkg::ADDR_W-1:0] paddr,
	input  logic [wra_pkg::DATA_W-1:0] pwdata,
	output logic [wra_pkg::DATA_W-1:0] prdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic out_free,
	output logic out_load,
	output wra_pkg::lane_ctl_t lane_ctl
);
	import wra_pkg::*;

	state_t state_q, state_d;
	logic [FRAC_W-1:0] window_len_q, xfade_q, mix_q;
	logic [FRAC_W-1:0] xf_sat, mix_sat;
	logic [LEN_W-1:0] pos_q, active_len_q, nearest_q, fade_q, rd_slot;
	logic cap_q, played_q;
	logic [LEN_W+FRAC_W-1:0] fade_prod;
	logic [LEN_W:0] rem_q;
	logic [FRAC_SH-1:0] quo_q, quo_next;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [FRAC_W-1:0] env_q;
	logic [LEN_W+1:0] step1, step2;
	logic [LEN_W:0] pos_inc;
	logic accept, wr_en, use_div, div_last;
	reg_idx_t reg_idx;

	// one restoring step: {quotient bit, remainder}
	function automatic logic [LEN_W+1:0] div_step(input logic [LEN_W:0] r,
		input logic [LEN_W-1:0] d);
		logic [LEN_W+1:0] r2;
		logic [LEN_W+1:0] res;
		r2 = {r, 1'b0};
		if (r2 >= (LEN_W + 2)'(d)) begin
			res = {1'b1, (LEN_W + 1)'(r2 - (LEN_W + 2)'(d))};
		end else begin
			res = {1'b0, r2[LEN_W:0]};
		end
		return res;
	endfunction

	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= FRAC_W'(WINDOW_LEN_RST);
			xfade_q <= FRAC_W'(CROSSFADE_RST);
			mix_q <= FRAC_W'(MIX_RST);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WINDOW_LEN: window_len_q <= pwdata[FRAC_W-1:0];
				REG_CROSSFADE:  xfade_q <= pwdata[FRAC_W-1:0];
				REG_MIX:        mix_q <= pwdata[FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WINDOW_LEN: prdata = DATA_W'(window_len_q);
			REG_CROSSFADE:  prdata = DATA_W'(xfade_q);
			REG_MIX:        prdata = DATA_W'(mix_q);
			default:        prdata = '0;
		endcase
	end

	assign xf_sat = (xfade_q > FRAC_W'(UNITY)) ? FRAC_W'(UNITY) : xfade_q;
	assign mix_sat = (mix_q > FRAC_W'(UNITY)) ? FRAC_W'(UNITY) : mix_q;

	assign accept = in_valid && in_ready;
	assign rd_slot = active_len_q - LEN_W'(1) - pos_q;
	assign fade_prod = (LEN_W + FRAC_W)'(active_len_q) * (LEN_W + FRAC_W)'(xf_sat);
	assign use_div = (fade_q != '0) && (nearest_q < fade_q);
	assign step1 = div_step(rem_q, fade_q);
	assign step2 = div_step(step1[LEN_W:0], fade_q);
	assign quo_next = {quo_q[FRAC_SH-3:0], step1[LEN_W+1], step2[LEN_W+1]};
	assign div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign pos_inc = (LEN_W + 1)'(pos_q) + (LEN_W + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_FADE;
			end
			ST_FADE: state_d = use_div ? ST_DIV : ST_WET;
			ST_DIV:  if (div_last) state_d = ST_WET;
			ST_WET:  state_d = ST_MIX;
			ST_MIX:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_OUT;
			ST_OUT: begin
				out_load = out_free;
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// envelope: position to fade ratio, two quotient bits a cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			fade_q <= fade_prod[LEN_W+FRAC_W-1:FADE_SH];
			nearest_q <= (pos_q < rd_slot) ? pos_q : rd_slot;
		end
		if (state_q == ST_FADE) begin
			rem_q <= {1'b0, nearest_q};
			quo_q <= '0;
			div_cnt_q <= '0;
			if (!use_div) env_q <= FRAC_W'(UNITY);
		end
		if (state_q == ST_DIV) begin
			rem_q <= step2[LEN_W:0];
			quo_q <= quo_next;
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			if (div_last) env_q <= {1'b0, quo_next};
		end
	end

	// window position and ping-pong swap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cap_q <= 1'b0;
			played_q <= 1'b0;
			active_len_q <= LEN_W'(ACTIVE_LEN_RST);
		end else if (out_load) begin
			if (pos_inc >= (LEN_W + 1)'(active_len_q)) begin
				pos_q <= '0;
				cap_q <= ~cap_q;
				played_q <= 1'b1;
				if (window_len_q != '0 && 32'(window_len_q) < 32'(MAX_WINDOW)) begin
					active_len_q <= LEN_W'(window_len_q);
				end
			end else begin
				pos_q <= pos_inc[LEN_W-1:0];
			end
		end
	end

	always_comb begin
		lane_ctl.mem_en = accept;
		lane_ctl.cap_half = cap_q;
		lane_ctl.wr_slot = pos_q;
		lane_ctl.rd_slot = rd_slot;
		lane_ctl.dry_en = (state_q == ST_FADE);
		lane_ctl.wet_en = (state_q == ST_WET);
		lane_ctl.mix_en = (state_q == ST_MIX);
		lane_ctl.sum_en = (state_q == ST_SUM);
		lane_ctl.played = played_q;
		lane_ctl.env = env_q;
		lane_ctl.mix = mix_sat;
		lane_ctl.mix_inv = FRAC_W'(UNITY) - mix_sat;
	end

endmodule

@@ hdl/wra_lane.sv @@
module wra_lane (
	input  logic clk,
	input  wra_pkg::lane_ctl_t ctl,
	input  logic signed [wra_pkg::SAMPLE_W-1:0] dry,
	output logic signed [wra_pkg::SAMPLE_W-1:0] result
);
	import wra_pkg::*;

	logic [SAMPLE_W-1:0] mem_q [0:2**(LEN_W+1)-1];
	logic [SAMPLE_W-1:0] rd_q;
	logic signed [SAMPLE_W-1:0] dry_q, wet_q, res_q;
	logic signed [PROD_W-1:0] dp_q, wm_q, wet_prod;

	// capture half written while the other half plays back
	always_ff @(posedge clk) begin
		if (ctl.mem_en) begin
			mem_q[{ctl.cap_half, ctl.wr_slot}] <= dry;
			rd_q <= mem_q[{~ctl.cap_half, ctl.rd_slot}];
			dry_q <= dry;
		end
	end

	assign wet_prod = PROD_W'($signed(rd_q)) * PROD_W'($signed({1'b0, ctl.env}));

	always_ff @(posedge clk) begin
		if (ctl.dry_en) dp_q <= PROD_W'(dry_q) * PROD_W'($signed({1'b0, ctl.mix_inv}));
		if (ctl.wet_en) begin
			wet_q <= ctl.played ? SAMPLE_W'(div_unity(ACC_W'(wet_prod))) : '0;
		end
		if (ctl.mix_en) wm_q <= PROD_W'(wet_q) * PROD_W'($signed({1'b0, ctl.mix}));
		if (ctl.sum_en) res_q <= sat_sample(div_unity(ACC_W'(dp_q) + ACC_W'(wm_q)));
	end

	assign result = res_q;

endmodule

@@ hdl/wra_merge.sv @@
module wra_merge (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic signed [wra_pkg::SAMPLE_W-1:0] lane_res [wra_pkg::LANES],
	input  logic out_ready,
	output logic out_valid,
	output logic signed [wra_pkg::SAMPLE_W-1:0] left_out,
	output logic signed [wra_pkg::SAMPLE_W-1:0] right_out,
	output logic free
);
	import wra_pkg::*;

	logic valid_q;
	logic signed [SAMPLE_W-1:0] left_q, right_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_q <= lane_res[0];
			right_q <= lane_res[1];
		end
	end

	assign out_valid = valid_q;
	assign left_out = left_q;
	assign right_out = right_q;

endmodule

@@ hdl/wra_checker.sv @@
module wra_checker (
	input logic clk,
	input logic arst_n,
	input logic pready,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [23:0] left_out,
	input logic [23:0] right_out
);

	// a stalled output transaction keeps its samples
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
		else $error("output changed while stalled");

	// a frame keeps the sequencer busy, with in_ready low, before the next one is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("input taken again too early");

	// a new result only appears out of the busy phase
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a frame in flight");

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid && pready)
		else $error("output valid during reset");

endmodule

bind windowed_reverse_audio_top wra_checker u_chk (.*);

@@ verif/tb.sv @@
module tb;
	import wra_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int FRAC_MAX = (1 << FRAC_W) - 1;
	localparam int WIN_CAP = 48;
	localparam int RAND_PER_STAGE = 400;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} stereo_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [SAMPLE_W-1:0] left_in, right_in, left_out, right_out;

	windowed_reverse_audio_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.left_in(left_in),
		.right_in(right_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_out(left_out),
		.right_out(right_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// reverse effect state, kept alongside the block
	logic cap_half;
	logic played;
	logic [LEN_W-1:0] frame_pos;
	logic [LEN_W-1:0] act_len;
	logic [FRAC_W-1:0] win_len_reg, xfade_reg, mix_reg;
	longint frame_mem [int];
	int half_fill [2];

	stereo_t pend_frames [$];
	stereo_t want_out [$];
	int bad_count = 0;
	int src_idle_pct, snk_idle_pct;
	bit in_took = 1'b0;

	function automatic int store_addr(input int half, input int plane, input longint slot);
		return ((half * 2 + plane) * MAX_WINDOW) + int'(slot);
	endfunction

	function automatic stereo_t reverse_frame(input stereo_t dry);
		longint len, pos, rd_slot, nearest, fade, env, xf, mx, smp, wet, acc;
		longint d [2];
		int pb, a;
		stereo_t res;
		len = act_len;
		if (len == 0 || len >= MAX_WINDOW) begin
			len = MAX_WINDOW - 1;
		end
		pos = frame_pos;
		if (pos >= len) begin
			pos = 0;
		end
		xf = (xfade_reg > UNITY) ? UNITY : xfade_reg;
		mx = (mix_reg > UNITY) ? UNITY : mix_reg;
		d[0] = $signed(dry.left);
		d[1] = $signed(dry.right);
		pb = int'(cap_half) ^ 1;
		rd_slot = len - 1 - pos;
		nearest = (pos < rd_slot) ? pos : rd_slot;
		fade = (len * xf) >> FADE_SH;
		env = UNITY;
		if (fade > 0 && nearest < fade) begin
			env = (nearest * UNITY) / fade;
		end
		for (int c = 0; c < 2; c++) begin
			frame_mem[store_addr(int'(cap_half), c, pos)] = d[c];
		end
		if (pos + 1 > half_fill[cap_half]) begin
			half_fill[cap_half] = int'(pos) + 1;
		end
		for (int c = 0; c < 2; c++) begin
			wet = 0;
			if (played) begin
				a = store_addr(pb, c, rd_slot);
				smp = frame_mem.exists(a) ? frame_mem[a] : 0;
				wet = (smp * env) / UNITY;
			end
			acc = (d[c] * (UNITY - mx) + wet * mx) / UNITY;
			if (acc > SAMPLE_MAX) begin
				acc = SAMPLE_MAX;
			end
			if (acc < SAMPLE_MIN) begin
				acc = SAMPLE_MIN;
			end
			if (c == 0) begin
				res.left = SAMPLE_W'(acc);
			end else begin
				res.right = SAMPLE_W'(acc);
			end
		end
		pos++;
		if (pos >= len) begin
			// window done: swap halves and take the new length if usable
			pos = 0;
			cap_half = pb[0];
			played = 1'b1;
			if (win_len_reg > 0 && win_len_reg < MAX_WINDOW) begin
				len = win_len_reg;
			end
		end
		frame_pos = LEN_W'(pos);
		act_len = LEN_W'(len);
		return res;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		logic signed [SAMPLE_W-1:0] s;
		case ($urandom_range(15))
			0: s = SAMPLE_W'(SAMPLE_MAX);
			1: s = SAMPLE_W'(SAMPLE_MIN);
			2: s = '0;
			3: s = '1;
			default: s = SAMPLE_W'($urandom);
		endcase
		return s;
	endfunction

	task automatic push_random(input int n);
		stereo_t f;
		for (int k = 0; k < n; k++) begin
			f.left = pick_sample();
			f.right = pick_sample();
			pend_frames.push_back(f);
		end
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [FRAC_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		case (idx)
			REG_WINDOW_LEN: win_len_reg = val;
			REG_CROSSFADE: xfade_reg = val;
			REG_MIX: mix_reg = val;
			default: ;
		endcase
		@(posedge clk);
		if (pready !== 1'b1) begin
			$display("%0t: pready expected 1 actual %0b", $time, pready);
			bad_count++;
		end
		@(negedge clk);
		if (idx == REG_SPARE) begin
			psel <= 1'b0;
			penable <= 1'b0;
		end else begin
			// read back from the same address
			penable <= 1'b0;
			pwrite <= 1'b0;
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			if (prdata !== DATA_W'(val)) begin
				$display("%0t: register %0d expected %0d actual %0d", $time, idx, val, prdata);
				bad_count++;
			end
			@(negedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	task automatic drain();
		while (pend_frames.size() != 0 || in_valid || want_out.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [FRAC_W-1:0] pick_frac();
		logic [FRAC_W-1:0] v;
		case ($urandom_range(7))
			0: v = '0;
			1: v = FRAC_W'(UNITY);
			2: v = FRAC_W'(FRAC_MAX);
			3: v = FRAC_W'($urandom_range(FRAC_MAX, UNITY + 1));
			default: v = FRAC_W'($urandom_range(UNITY));
		endcase
		return v;
	endfunction

	// a new length must not outrun what the next playback half will hold
	function automatic int legal_len();
		int lim, wl;
		lim = (half_fill[cap_half] > int'(act_len)) ? half_fill[cap_half] : int'(act_len);
		if (lim > WIN_CAP) begin
			lim = WIN_CAP;
		end
		case ($urandom_range(9))
			0: wl = 0;
			1: wl = 1;
			2: wl = lim;
			default: wl = $urandom_range(lim, 1);
		endcase
		return wl;
	endfunction

	// input side
	always @(negedge clk) begin
		stereo_t nxt;
		if (!in_valid || in_took) begin
			in_took = 1'b0;
			if (pend_frames.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt = pend_frames.pop_front();
				in_valid <= 1'b1;
				left_in <= nxt.left;
				right_in <= nxt.right;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// both transaction sides, output first so a same-edge input cannot satisfy it
	always @(posedge clk) begin
		stereo_t want, dry;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (want_out.size() == 0) begin
					$display("%0t: unexpected result expected none actual %0d %0d", $time,
						left_out, right_out);
					bad_count++;
				end else begin
					want = want_out.pop_front();
					if (left_out !== want.left) begin
						$display("%0t: left_out expected %0d actual %0d", $time,
							$signed(want.left), left_out);
						bad_count++;
					end
					if (right_out !== want.right) begin
						$display("%0t: right_out expected %0d actual %0d", $time,
							$signed(want.right), right_out);
						bad_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				dry.left = left_in;
				dry.right = right_in;
				want_out.push_back(reverse_frame(dry));
				in_took = 1'b1;
			end
		end
	end

	initial begin
		stereo_t corner_frames [5];
		int dir_mix [4];
		int done;
		in_valid = 1'b0;
		left_in = '0;
		right_in = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		cap_half = 1'b0;
		played = 1'b0;
		frame_pos = '0;
		act_len = LEN_W'(ACTIVE_LEN_RST);
		win_len_reg = FRAC_W'(WINDOW_LEN_RST);
		xfade_reg = FRAC_W'(CROSSFADE_RST);
		mix_reg = FRAC_W'(MIX_RST);
		half_fill[0] = 0;
		half_fill[1] = 0;
		src_idle_pct = 38;
		snk_idle_pct = 84;
		corner_frames[0] = {SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MIN)};
		corner_frames[1] = {SAMPLE_W'(SAMPLE_MIN), SAMPLE_W'(SAMPLE_MAX)};
		corner_frames[2] = {SAMPLE_W'(0), SAMPLE_W'(-1)};
		corner_frames[3] = {SAMPLE_W'(-1), SAMPLE_W'(0)};
		corner_frames[4] = {SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MAX)};
		dir_mix[0] = MIX_RST;
		dir_mix[1] = 0;
		dir_mix[2] = UNITY / 2;
		dir_mix[3] = FRAC_MAX;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first window: no wet signal yet, so only the dry path, scaled by one minus the mix, shows at every mix
		for (int g = 0; g < 4; g++) begin
			if (g > 0) begin
				reg_write(REG_MIX, FRAC_W'(dir_mix[g]));
			end
			if (g == 1) begin
				reg_write(REG_WINDOW_LEN, FRAC_W'(FRAC_MAX));
				reg_write(REG_CROSSFADE, FRAC_W'(FRAC_MAX));
				reg_write(REG_SPARE, FRAC_W'($urandom));
			end
			for (int k = 0; k < 5; k++) begin
				pend_frames.push_back(corner_frames[k]);
			end
			push_random(1);
			drain();
		end

		// run out the reset-length window so the halves start swapping
		reg_write(REG_WINDOW_LEN, FRAC_W'($urandom_range(WIN_CAP, 1)));
		reg_write(REG_CROSSFADE, '0);
		reg_write(REG_MIX, pick_frac());
		push_random(int'(act_len) - int'(frame_pos));
		drain();

		for (int stage = 0; stage < 3; stage++) begin
			if (stage == 1) begin
				src_idle_pct = 84;
				snk_idle_pct = 38;
			end else if (stage == 2) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			done = 0;
			while (done < RAND_PER_STAGE) begin
				reg_write(REG_WINDOW_LEN, FRAC_W'(legal_len()));
				reg_write(REG_CROSSFADE, pick_frac());
				reg_write(REG_MIX, pick_frac());
				push_random($urandom_range(60, 8));
				done += pend_frames.size();
				drain();
			end
		end

		repeat (40) @(posedge clk);
		if (bad_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
